FILE: design/gnia_pkg.sv
`default_nettype none

package gnia_pkg;

	localparam int DIST_W = 23;
	localparam int ID_W   = 31;
	localparam int SQ_W   = 2 * DIST_W;
	localparam int SUM_W  = SQ_W + 2;

	localparam logic [DIST_W-1:0] DIST_RESET = 23'd512;

	localparam logic [1:0] CMD_BEGIN = 2'd0;
	localparam logic [1:0] CMD_LOAD  = 2'd1;
	localparam logic [1:0] CMD_MATCH = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_EXEC,
		S_MSTART,
		S_MINIT,
		S_AX0,
		S_AX1,
		S_AX2,
		S_AX3,
		S_CMP,
		S_MFIN
	} state_t;

endpackage

`default_nettype wire

FILE: design/greedy_nearest_id_assign_core.sv
`default_nettype none

// Greedy nearest-neighbour track id assignment. The previous centroids and their ids sit in a
// memory of MAX_PREV entries with one read port; a match request walks the N loaded entries
// one after another, through the states S_AX0 to S_AX3 and S_CMP for each, because a single
// 23 by 23 bit squaring multiplier is shared by the three axes of every entry. A match thus
// occupies the block until its scan ends, while begin-frame, load and unknown requests pass
// through S_EXEC alone. Only one request is in work at a time; the result waits in an output
// register, so a stalled consumer holds back at most the finish of the next request. No
// clearing pass is needed after reset: entries at or above the fill count are never used.
module greedy_nearest_id_assign_core #(
	parameter int MAX_PREV   = 64,
	parameter int COORD_BITS = 24
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          cfg_valid,
	output logic                         cfg_ready,
	input  wire  [gnia_pkg::DIST_W-1:0]  cfg_data,
	input  wire                          in_valid,
	output logic                         in_ready,
	input  wire  [1:0]                   cmd,
	input  wire  signed [COORD_BITS-1:0] pos_x,
	input  wire  signed [COORD_BITS-1:0] pos_y,
	input  wire  signed [COORD_BITS-1:0] pos_z,
	input  wire  [gnia_pkg::ID_W-1:0]    entry_id,
	output logic                         out_valid,
	input  wire                          out_ready,
	output logic [gnia_pkg::ID_W-1:0]    assigned_id,
	output logic                         matched,
	output logic                         table_full
);

	localparam int IW   = (MAX_PREV > 1) ? $clog2(MAX_PREV) : 1;
	localparam int CNTW = $clog2(MAX_PREV + 1);
	localparam int AW   = COORD_BITS + 1;
	localparam int EW   = (AW > gnia_pkg::DIST_W) ? AW : gnia_pkg::DIST_W;

	gnia_pkg::state_t state_q, state_d;

	logic [gnia_pkg::DIST_W-1:0] md_q;
	logic [CNTW-1:0]             count_q;
	logic [CNTW-1:0]             j_q;
	logic [gnia_pkg::ID_W-1:0]   fresh_q;

	logic [1:0]                  cmd_q;
	logic signed [COORD_BITS-1:0] in_x_q, in_y_q, in_z_q;
	logic [gnia_pkg::ID_W-1:0]   in_id_q;

	logic signed [COORD_BITS-1:0] mem_x [MAX_PREV];
	logic signed [COORD_BITS-1:0] mem_y [MAX_PREV];
	logic signed [COORD_BITS-1:0] mem_z [MAX_PREV];
	logic [gnia_pkg::ID_W-1:0]    mem_trk [MAX_PREV];
	logic                         mem_used [MAX_PREV];

	logic signed [COORD_BITS-1:0] rd_x_q, rd_y_q, rd_z_q;
	logic [gnia_pkg::ID_W-1:0]    rd_trk_q;
	logic                         rd_used_q;

	logic [gnia_pkg::DIST_W-1:0] diff_q;
	logic                        far_q;
	logic                        cand_used_q;
	logic [gnia_pkg::ID_W-1:0]   cand_trk_q;
	logic [gnia_pkg::SQ_W-1:0]   prod_q;
	logic [gnia_pkg::SUM_W-1:0]  acc_q;
	logic [gnia_pkg::SUM_W-1:0]  best_q;
	logic [IW-1:0]               best_idx_q;
	logic [gnia_pkg::ID_W-1:0]   best_trk_q;
	logic                        hit_q;

	logic                        out_free;
	logic                        rd_en;
	logic [IW-1:0]               rd_addr;
	logic                        exec_go;
	logic                        mfin_go;
	logic                        is_full;
	logic                        last_entry;
	logic [gnia_pkg::DIST_W-1:0] mul_a;
	logic [gnia_pkg::SQ_W-1:0]   mul_p;
	logic signed [COORD_BITS-1:0] sel_in, sel_rd;
	logic signed [AW-1:0]        sub_d;
	logic [AW-1:0]               abs_d;
	logic                        axis_far;
	logic [gnia_pkg::SUM_W-1:0]  dist_sum;
	logic                        take;
	logic [CNTW-1:0]             j_inc;

	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid || out_ready;
	assign is_full   = (count_q == CNTW'(MAX_PREV));
	assign j_inc     = j_q + CNTW'(1);
	assign last_entry = (j_inc == count_q);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			gnia_pkg::S_IDLE: begin
				if (in_valid) begin
					state_d = (cmd == gnia_pkg::CMD_MATCH) ? gnia_pkg::S_MSTART
						: gnia_pkg::S_EXEC;
				end
			end
			gnia_pkg::S_EXEC: begin
				if (out_free) begin
					state_d = gnia_pkg::S_IDLE;
				end
			end
			gnia_pkg::S_MSTART: state_d = gnia_pkg::S_MINIT;
			gnia_pkg::S_MINIT: begin
				state_d = (count_q == '0) ? gnia_pkg::S_MFIN : gnia_pkg::S_AX0;
			end
			gnia_pkg::S_AX0: state_d = gnia_pkg::S_AX1;
			gnia_pkg::S_AX1: state_d = gnia_pkg::S_AX2;
			gnia_pkg::S_AX2: state_d = gnia_pkg::S_AX3;
			gnia_pkg::S_AX3: state_d = gnia_pkg::S_CMP;
			gnia_pkg::S_CMP: begin
				state_d = last_entry ? gnia_pkg::S_MFIN : gnia_pkg::S_AX0;
			end
			gnia_pkg::S_MFIN: begin
				if (out_free) begin
					state_d = gnia_pkg::S_IDLE;
				end
			end
			default: state_d = gnia_pkg::S_IDLE;
		endcase
	end

	// Control outputs of the sequencer.
	always_comb begin
		in_ready = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = '0;
		exec_go  = 1'b0;
		mfin_go  = 1'b0;
		mul_a    = diff_q;
		sel_in   = in_x_q;
		sel_rd   = rd_x_q;
		case (state_q)
			gnia_pkg::S_IDLE: in_ready = 1'b1;
			gnia_pkg::S_EXEC: exec_go = out_free;
			gnia_pkg::S_MSTART: begin
				rd_en = 1'b1;
				mul_a = md_q;
			end
			gnia_pkg::S_AX1: begin
				sel_in = in_y_q;
				sel_rd = rd_y_q;
			end
			gnia_pkg::S_AX2: begin
				sel_in = in_z_q;
				sel_rd = rd_z_q;
			end
			gnia_pkg::S_AX3: begin
				rd_en   = 1'b1;
				rd_addr = j_inc[IW-1:0];
			end
			gnia_pkg::S_MFIN: mfin_go = out_free;
			default: ;
		endcase
	end

	// Shared arithmetic: one absolute difference and one squarer.
	assign sub_d    = AW'(sel_in) - AW'(sel_rd);
	assign abs_d    = sub_d[AW-1] ? AW'(-sub_d) : AW'(sub_d);
	assign axis_far = (EW'(abs_d) > EW'(md_q));
	assign mul_p    = gnia_pkg::SQ_W'(mul_a) * gnia_pkg::SQ_W'(mul_a);
	assign dist_sum = acc_q + gnia_pkg::SUM_W'(prod_q);
	assign take     = !far_q && !cand_used_q && (dist_sum <= best_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= gnia_pkg::S_IDLE;
			md_q        <= gnia_pkg::DIST_RESET;
			count_q     <= '0;
			fresh_q     <= '0;
			out_valid   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid) begin
				md_q <= cfg_data;
			end
			out_valid <= exec_go || mfin_go || (out_valid && !out_ready);
			if (exec_go) begin
				case (cmd_q)
					gnia_pkg::CMD_BEGIN: count_q <= '0;
					gnia_pkg::CMD_LOAD: begin
						if (!is_full) begin
							count_q <= count_q + CNTW'(1);
						end
					end
					default: ;
				endcase
			end
			if (mfin_go) begin
				if (!hit_q) begin
					fresh_q <= fresh_q + gnia_pkg::ID_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_q   <= cmd;
			in_x_q  <= pos_x;
			in_y_q  <= pos_y;
			in_z_q  <= pos_z;
			in_id_q <= entry_id;
		end
		if (exec_go) begin
			assigned_id <= '0;
			matched     <= 1'b0;
			table_full  <= (cmd_q == gnia_pkg::CMD_LOAD) && is_full;
		end
		if (mfin_go) begin
			assigned_id <= hit_q ? best_trk_q : fresh_q;
			matched     <= hit_q;
			table_full  <= 1'b0;
		end
		case (state_q)
			gnia_pkg::S_MSTART: begin
				prod_q <= mul_p;
				hit_q  <= 1'b0;
				j_q    <= '0;
			end
			gnia_pkg::S_MINIT: best_q <= gnia_pkg::SUM_W'(prod_q);
			gnia_pkg::S_AX0: begin
				diff_q      <= abs_d[gnia_pkg::DIST_W-1:0];
				far_q       <= axis_far;
				cand_used_q <= rd_used_q;
				cand_trk_q  <= rd_trk_q;
			end
			gnia_pkg::S_AX1: begin
				prod_q <= mul_p;
				diff_q <= abs_d[gnia_pkg::DIST_W-1:0];
				far_q  <= far_q || axis_far;
			end
			gnia_pkg::S_AX2: begin
				acc_q  <= gnia_pkg::SUM_W'(prod_q);
				prod_q <= mul_p;
				diff_q <= abs_d[gnia_pkg::DIST_W-1:0];
				far_q  <= far_q || axis_far;
			end
			gnia_pkg::S_AX3: begin
				acc_q  <= dist_sum;
				prod_q <= mul_p;
			end
			gnia_pkg::S_CMP: begin
				if (take) begin
					best_q     <= dist_sum;
					best_idx_q <= j_q[IW-1:0];
					best_trk_q <= cand_trk_q;
					hit_q      <= 1'b1;
				end
				j_q <= j_inc;
			end
			default: ;
		endcase
	end

	// Entry table: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (exec_go && (cmd_q == gnia_pkg::CMD_LOAD) && !is_full) begin
			mem_x[count_q[IW-1:0]]    <= in_x_q;
			mem_y[count_q[IW-1:0]]    <= in_y_q;
			mem_z[count_q[IW-1:0]]    <= in_z_q;
			mem_trk[count_q[IW-1:0]]  <= in_id_q;
			mem_used[count_q[IW-1:0]] <= 1'b0;
		end else if (mfin_go && hit_q) begin
			mem_used[best_idx_q] <= 1'b1;
		end
		if (rd_en) begin
			rd_x_q    <= mem_x[rd_addr];
			rd_y_q    <= mem_y[rd_addr];
			rd_z_q    <= mem_z[rd_addr];
			rd_trk_q  <= mem_trk[rd_addr];
			rd_used_q <= mem_used[rd_addr];
		end
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q != gnia_pkg::S_IDLE)
		else $error("block still idle after accepting a request");

	a_scan_step: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == gnia_pkg::S_CMP |=> state_q == gnia_pkg::S_AX0 || state_q == gnia_pkg::S_MFIN)
		else $error("scan left the compare step out of order");

	a_full_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && table_full |-> !matched && assigned_id == '0)
		else $error("dropped load reported with an id");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNTW'(MAX_PREV))
		else $error("fill count beyond table depth");

endmodule

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;

	localparam int DIST_W = gnia_pkg::DIST_W;
	localparam int ID_W = gnia_pkg::ID_W;
	localparam logic [1:0] CMD_BEGIN = gnia_pkg::CMD_BEGIN;
	localparam logic [1:0] CMD_LOAD = gnia_pkg::CMD_LOAD;
	localparam logic [1:0] CMD_MATCH = gnia_pkg::CMD_MATCH;
	localparam logic [DIST_W-1:0] DIST_RESET = gnia_pkg::DIST_RESET;

	localparam int TRACK_SLOTS = 64;
	localparam int COORD_W = 24;
	localparam int ITEM_TARGET = 1800;
	localparam int STALL_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam logic [1:0] CMD_UNKNOWN = 2'd3;
	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
	localparam logic [ID_W-1:0] ID_ALL_ONES = {ID_W{1'b1}};

	typedef logic signed [COORD_W-1:0] coord_t;

	localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

	typedef struct {
		logic [1:0] op;
		coord_t x;
		coord_t y;
		coord_t z;
		logic [ID_W-1:0] id;
	} request_t;

	typedef struct {
		logic [ID_W-1:0] id;
		logic hit;
		logic full;
	} assignment_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [DIST_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] cmd = CMD_BEGIN;
	coord_t pos_x = '0;
	coord_t pos_y = '0;
	coord_t pos_z = '0;
	logic [ID_W-1:0] entry_id = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [ID_W-1:0] assigned_id;
	logic matched;
	logic table_full;

	coord_t track_x [TRACK_SLOTS];
	coord_t track_y [TRACK_SLOTS];
	coord_t track_z [TRACK_SLOTS];
	logic [ID_W-1:0] track_id [TRACK_SLOTS];
	bit track_used [TRACK_SLOTS];
	int track_count = 0;
	logic [ID_W-1:0] next_fresh_id = '0;
	logic [DIST_W-1:0] match_dist = DIST_RESET;

	assignment_t pending_assignments[$];
	request_t frame_loads[$];
	int error_count = 0;
	int sent_count = 0;
	int idle_cycles = 0;
	int rx_hold_cycles = 0;
	bit tx_idle_on = 1'b1;
	bit rx_idle_on = 1'b1;

	greedy_nearest_id_assign_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.cmd(cmd),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.pos_z(pos_z),
		.entry_id(entry_id),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.assigned_id(assigned_id),
		.matched(matched),
		.table_full(table_full)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint unsigned axis_gap(longint a, longint b);
		return (a >= b) ? a - b : b - a;
	endfunction

	function automatic assignment_t predict_assignment(request_t rq);
		assignment_t res;
		longint unsigned md, best, dx, dy, dz, d2;
		int best_slot;
		int j;
		bit hit;
		res.id = '0;
		res.hit = 1'b0;
		res.full = 1'b0;
		md = match_dist;
		best = md * md;
		best_slot = 0;
		hit = 1'b0;
		case (rq.op)
			CMD_BEGIN: begin
				track_count = 0;
				foreach (track_used[i]) track_used[i] = 1'b0;
			end
			CMD_LOAD: begin
				if (track_count >= TRACK_SLOTS) begin
					res.full = 1'b1;
				end else begin
					track_x[track_count] = rq.x;
					track_y[track_count] = rq.y;
					track_z[track_count] = rq.z;
					track_id[track_count] = rq.id;
					track_used[track_count] = 1'b0;
					track_count++;
				end
			end
			CMD_MATCH: begin
				for (j = 0; j < track_count; j++) begin
					if (track_used[j]) continue;
					dx = axis_gap(rq.x, track_x[j]);
					dy = axis_gap(rq.y, track_y[j]);
					dz = axis_gap(rq.z, track_z[j]);
					if (dx > md || dy > md || dz > md) continue;
					d2 = dx * dx + dy * dy + dz * dz;
					// Later entries win ties, hence the non-strict comparison.
					if (d2 <= best) begin
						best = d2;
						best_slot = j;
						hit = 1'b1;
					end
				end
				if (hit) begin
					res.id = track_id[best_slot];
					res.hit = 1'b1;
					track_used[best_slot] = 1'b1;
				end else begin
					res.id = next_fresh_id;
					next_fresh_id = next_fresh_id + 1'b1;
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	function automatic coord_t near_coord(coord_t base, longint unsigned spread);
		longint off;
		off = longint'($urandom_range(0, 32'(2 * spread))) - longint'(spread);
		return coord_t'(base + off);
	endfunction

	task automatic send_request(input logic [1:0] op, input coord_t x, input coord_t y,
			input coord_t z, input logic [ID_W-1:0] id);
		int gap;
		request_t rq;
		gap = tx_idle_on ? $urandom_range(0, 7) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= op;
		pos_x <= x;
		pos_y <= y;
		pos_z <= z;
		entry_id <= id;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		rq = '{op, x, y, z, id};
		pending_assignments.insert(pending_assignments.size(), predict_assignment(rq));
		if (op != CMD_UNKNOWN) sent_count++;
	endtask

	task automatic settle_block();
		in_valid <= 1'b0;
		while (pending_assignments.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_match_distance(input logic [DIST_W-1:0] value);
		settle_block();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		match_dist = value;
	endtask

	task automatic test_directed_cases();
		tx_idle_on = 1'b1;
		rx_idle_on = 1'b1;
		send_request(CMD_MATCH, 0, 0, 0, ID_ALL_ONES);
		send_request(CMD_UNKNOWN, COORD_MIN, COORD_MAX, -1, ID_ALL_ONES);
		send_request(CMD_BEGIN, COORD_MAX, COORD_MIN, 0, ID_W'($urandom));
		send_request(CMD_LOAD, COORD_MAX, COORD_MAX, COORD_MAX, ID_ALL_ONES);
		send_request(CMD_LOAD, COORD_MIN, COORD_MIN, COORD_MIN, '0);
		send_request(CMD_LOAD, 0, 0, 0, ID_W'(5));
		send_request(CMD_LOAD, 0, 0, 0, ID_W'(6));
		// Two equal entries: the later one is taken first, then the earlier one.
		send_request(CMD_MATCH, 0, 0, 0, ID_W'($urandom));
		send_request(CMD_MATCH, 0, 0, 0, ID_W'($urandom));
		send_request(CMD_MATCH, 0, 0, 0, ID_W'($urandom));
		send_request(CMD_MATCH, COORD_MAX - 300, COORD_MAX - 300, COORD_MAX - 300, '0);
		send_request(CMD_MATCH, COORD_MAX - 200, COORD_MAX, COORD_MAX, '0);
		send_request(CMD_MATCH, COORD_MIN + 513, COORD_MIN, COORD_MIN, '0);
		send_request(CMD_MATCH, COORD_MIN + 512, COORD_MIN, COORD_MIN, '0);
		send_request(CMD_MATCH, 1, -1, 0, '0);
		send_request(CMD_BEGIN, 0, 0, 0, '0);
		send_request(CMD_MATCH, 0, 0, 0, '0);
		send_request(CMD_LOAD, 0, 0, 0, ID_W'(9));
		send_request(CMD_MATCH, 0, 0, 0, '0);
	endtask

	task automatic test_distance_extremes();
		set_match_distance('0);
		send_request(CMD_BEGIN, 0, 0, 0, '0);
		send_request(CMD_LOAD, 1, 2, 3, ID_W'($urandom));
		send_request(CMD_LOAD, -5, -5, -5, ID_W'($urandom));
		send_request(CMD_MATCH, 1, 2, 4, '0);
		send_request(CMD_MATCH, 1, 2, 3, '0);
		send_request(CMD_MATCH, -5, -5, -5, '0);
		set_match_distance(DIST_MAX);
		send_request(CMD_BEGIN, 0, 0, 0, '0);
		send_request(CMD_LOAD, COORD_MIN, COORD_MIN, COORD_MIN, ID_W'($urandom));
		send_request(CMD_LOAD, COORD_MAX, COORD_MAX, COORD_MAX, ID_W'($urandom));
		send_request(CMD_MATCH, 0, 0, 0, '0);
		send_request(CMD_MATCH, COORD_MAX, COORD_MAX, 0, '0);
		send_request(CMD_MATCH, COORD_MIN, COORD_MIN, -1, '0);
	endtask

	task automatic test_table_overflow();
		request_t rq;
		int i;
		set_match_distance(DIST_W'($urandom_range(1000, 100000)));
		send_request(CMD_BEGIN, 0, 0, 0, '0);
		frame_loads.delete();
		for (i = 0; i < TRACK_SLOTS + 3; i++) begin
			rq = '{CMD_LOAD, coord_t'($urandom), coord_t'($urandom), coord_t'($urandom),
				ID_W'($urandom)};
			send_request(rq.op, rq.x, rq.y, rq.z, rq.id);
			if (frame_loads.size() < TRACK_SLOTS) frame_loads.insert(frame_loads.size(), rq);
		end
		for (i = 0; i < 6; i++) begin
			rq = frame_loads[$urandom_range(0, frame_loads.size() - 1)];
			send_request(CMD_MATCH, rq.x, rq.y, rq.z, '0);
		end
	endtask

	task automatic test_output_backpressure();
		coord_t cx, cy, cz;
		int i;
		set_match_distance(DIST_RESET);
		tx_idle_on = 1'b0;
		rx_hold_cycles = HOLD_OFF_CYCLES;
		cx = coord_t'($urandom);
		cy = coord_t'($urandom);
		cz = coord_t'($urandom);
		send_request(CMD_BEGIN, 0, 0, 0, '0);
		for (i = 0; i < 6; i++) begin
			send_request(CMD_LOAD, near_coord(cx, 400), near_coord(cy, 400),
				near_coord(cz, 400), ID_W'($urandom));
		end
		for (i = 0; i < 14; i++) begin
			send_request(CMD_MATCH, near_coord(cx, 400), near_coord(cy, 400),
				near_coord(cz, 400), '0);
		end
		tx_idle_on = 1'b1;
	endtask

	task automatic test_random_frames();
		int phase;
		int phase_end;
		int n_loads;
		int n_matches;
		int i;
		bit open_frame;
		bit clustered;
		longint unsigned md;
		longint unsigned spread;
		logic [DIST_W-1:0] md_value;
		coord_t cx, cy, cz, x, y, z;
		request_t rq;
		phase = 0;
		open_frame = 1'b1;
		while (sent_count < ITEM_TARGET) begin
			case (phase % 6)
				0: md_value = DIST_W'($urandom_range(1, 64));
				1: md_value = '0;
				2: md_value = DIST_MAX;
				3: md_value = DIST_RESET;
				4: md_value = DIST_W'($urandom_range(65, 200000));
				default: md_value = DIST_W'($urandom);
			endcase
			set_match_distance(md_value);
			md = md_value;
			tx_idle_on = ($urandom_range(0, 3) != 0);
			rx_idle_on = ($urandom_range(0, 3) != 0);
			phase_end = sent_count + 200;
			while (sent_count < phase_end && sent_count < ITEM_TARGET) begin
				if (open_frame || $urandom_range(0, 7) != 0) begin
					send_request(CMD_BEGIN, coord_t'($urandom), coord_t'($urandom),
						coord_t'($urandom), ID_W'($urandom));
					frame_loads.delete();
					open_frame = 1'b0;
				end
				n_loads = ($urandom_range(0, 9) == 0) ? $urandom_range(56, 68)
					: $urandom_range(0, 12);
				clustered = ($urandom_range(0, 3) != 0);
				cx = coord_t'($urandom);
				cy = coord_t'($urandom);
				cz = coord_t'($urandom);
				for (i = 0; i < n_loads; i++) begin
					if (frame_loads.size() > 0 && $urandom_range(0, 5) == 0) begin
						rq = frame_loads[$urandom_range(0, frame_loads.size() - 1)];
						x = rq.x;
						y = rq.y;
						z = rq.z;
					end else if (clustered) begin
						x = near_coord(cx, md + 16);
						y = near_coord(cy, md + 16);
						z = near_coord(cz, md + 16);
					end else begin
						x = coord_t'($urandom);
						y = coord_t'($urandom);
						z = coord_t'($urandom);
					end
					rq = '{CMD_LOAD, x, y, z, ID_W'($urandom)};
					send_request(rq.op, rq.x, rq.y, rq.z, rq.id);
					if (frame_loads.size() < TRACK_SLOTS) begin
						frame_loads.insert(frame_loads.size(), rq);
					end
				end
				n_matches = $urandom_range(1, (frame_loads.size() < 12)
					? frame_loads.size() + 3 : 24);
				for (i = 0; i < n_matches; i++) begin
					case ($urandom_range(0, 9))
						7: send_request(CMD_MATCH, coord_t'($urandom), coord_t'($urandom),
							coord_t'($urandom), ID_W'($urandom));
						8: send_request(CMD_UNKNOWN, coord_t'($urandom),
							coord_t'($urandom), coord_t'($urandom), ID_W'($urandom));
						9: send_request(CMD_MATCH, near_coord(cx, 2 * md + 1),
							near_coord(cy, 2 * md + 1), near_coord(cz, 2 * md + 1),
							ID_W'($urandom));
						default: begin
							if (frame_loads.size() == 0) begin
								rq = '{CMD_MATCH, cx, cy, cz, '0};
							end else begin
								rq = frame_loads[$urandom_range(0, frame_loads.size() - 1)];
							end
							case ($urandom_range(0, 3))
								0: spread = 0;
								1: spread = md / 2;
								2: spread = md;
								default: spread = md + md / 2 + 1;
							endcase
							send_request(CMD_MATCH, near_coord(rq.x, spread),
								near_coord(rq.y, spread), near_coord(rq.z, spread),
								ID_W'($urandom));
						end
					endcase
				end
			end
			phase++;
		end
	endtask

	initial begin : result_checker
		int stall;
		assignment_t want;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			stall = rx_idle_on ? $urandom_range(0, 7) : 0;
			if (rx_hold_cycles > 0) begin
				stall = rx_hold_cycles;
				rx_hold_cycles = 0;
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			if (pending_assignments.size() == 0) begin
				error_count++;
				if (error_count <= 10) begin
					$display("result with no request pending: id %0d matched %0b full %0b",
						assigned_id, matched, table_full);
				end
			end else begin
				want = pending_assignments.pop_front();
				if (assigned_id !== want.id || matched !== want.hit
						|| table_full !== want.full) begin
					error_count++;
					if (error_count <= 10) begin
						$display(
							"mismatch: expected id/matched/full %0d/%0b/%0b, got %0d/%0b/%0b",
							want.id, want.hit, want.full, assigned_id, matched, table_full);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_cases();
		test_distance_extremes();
		test_table_overflow();
		test_output_backpressure();
		test_random_frames();
		settle_block();
		repeat (40) @(posedge clk);
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
